/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while reset is released.
`define KSLE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define KSLE_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KSLE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ksle_pkg.sv */
package ksle_pkg;

  localparam int unsigned MaxElementsDef = 16;
  localparam int unsigned ValueWidthDef  = 32;

  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 5;

  localparam logic [CfgDataWidth-1:0] ElementCountReset = 5'd16;
  localparam logic [CfgDataWidth-1:0] ChosenCountReset  = 5'd1;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 4;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ELEMENT_COUNT = 1'b0,
    CFG_CHOSEN_COUNT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NEXT    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NEXT    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  load_index;
    logic [31:0] load_value;
  } in_t;

  typedef struct packed {
    logic [31:0] element_value;
    logic [3:0]  element_index;
    logic [3:0]  group_position;
    logic        in_subset;
    logic        last_item;
    logic        exhausted;
  } out_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  load_index;
    logic [31:0] load_value;
  } cmd_t;

endpackage

/* design/ksle_ram.sv */
module ksle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ksle_fifo.sv */
module ksle_fifo #(
  parameter type item_t = logic,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  item_t            data_i,
  output logic             full_o,
  input  logic             pop_i,
  output item_t            data_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  item_t            slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             enq, deq;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = slot_q[rd_q];
  assign enq     = push_i && !full_o;
  assign deq     = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q + CNT_W'(enq) - CNT_W'(deq);
    if (enq) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (deq) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

/* design/ksle_front.sv */
module ksle_front #(
  parameter int unsigned MAX_ELEMENTS = ksle_pkg::MaxElementsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  ksle_pkg::in_t  in_word_i,
  output logic           cmd_valid_o,
  input  logic           cmd_pop_i,
  output ksle_pkg::cmd_t cmd_o
);

  import ksle_pkg::*;

  cmd_t cmd_d;
  logic keep;
  logic cmd_empty;

  always_comb begin
    cmd_d.kind       = CMD_NEXT;
    cmd_d.load_index = in_word_i.load_index;
    cmd_d.load_value = in_word_i.load_value;
    keep             = 1'b0;
    case (in_word_i.operation)
      OP_LOAD: begin
        cmd_d.kind = CMD_LOAD;
        keep       = (32'(in_word_i.load_index) < MAX_ELEMENTS);
      end
      OP_NEXT: begin
        cmd_d.kind = CMD_NEXT;
        keep       = 1'b1;
      end
      OP_RESTART: begin
        cmd_d.kind = CMD_RESTART;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  ksle_fifo #(
    .item_t(cmd_t),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && keep),
    .data_i (cmd_d),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(cmd_empty),
    .count_o()
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

/* design/ksle_back.sv */
module ksle_back #(
  parameter int unsigned MAX_ELEMENTS = ksle_pkg::MaxElementsDef,
  parameter int unsigned VALUE_WIDTH  = ksle_pkg::ValueWidthDef,
  localparam int unsigned IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int unsigned OUT_CNT_W = $clog2(ksle_pkg::OutDepth + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ksle_pkg::CfgDataWidth-1:0] element_count_i,
  input  logic [ksle_pkg::CfgDataWidth-1:0] chosen_count_i,
  input  logic                              cmd_valid_i,
  input  ksle_pkg::cmd_t                    cmd_i,
  output logic                              cmd_pop_o,
  output logic                              out_push_o,
  output ksle_pkg::out_t                    out_word_o,
  input  logic [OUT_CNT_W-1:0]              out_count_i,
  output logic                              ram_we_o,
  output logic [IDX_W-1:0]                  ram_waddr_o,
  output logic [VALUE_WIDTH-1:0]            ram_wdata_o,
  output logic                              ram_re_o,
  output logic [IDX_W-1:0]                  ram_raddr_o,
  input  logic [VALUE_WIDTH-1:0]            ram_rdata_i
);

  import ksle_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMP_W = (CNT_W > CfgDataWidth) ? CNT_W : CfgDataWidth;
  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_EMIT_IN  = 5'b00100,
    ST_EMIT_OUT = 5'b01000,
    ST_EXHAUST  = 5'b10000
  } back_state_e;

  typedef struct packed {
    logic       exhausted;
    logic [3:0] element_index;
    logic [3:0] group_position;
    logic       in_subset;
    logic       last_item;
  } meta_t;

  back_state_e             state_q, state_d;
  logic                    started_q, started_d;
  logic                    done_q, done_d;
  logic [MAX_ELEMENTS-1:0] mask_q, mask_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic                    prev_q, prev_d;
  logic [CNT_W-1:0]        ones_q, ones_d;
  logic [CNT_W-1:0]        rcnt_q, rcnt_d;
  logic                    meta_valid_q, meta_valid_d;
  meta_t                   meta_q, meta_d;

  logic [CMP_W-1:0]        ec_w, ck_w, n_w, k_w;
  logic [CNT_W-1:0]        n_cnt, k_cnt, n_last;
  logic [MAX_ELEMENTS-1:0] mask_init, mask_adv;
  logic [SUM_W-1:0]        adv_hi, lane;
  logic [OUT_CNT_W:0]      used;
  logic                    space, cur, at_end, is_last;

  always_comb begin
    ec_w = CMP_W'(element_count_i);
    ck_w = CMP_W'(chosen_count_i);
    if (ec_w == '0) begin
      n_w = CMP_W'(1);
    end else if (ec_w > CMP_W'(MAX_ELEMENTS)) begin
      n_w = CMP_W'(MAX_ELEMENTS);
    end else begin
      n_w = ec_w;
    end
    k_w    = (ck_w > n_w) ? n_w : ck_w;
    n_cnt  = CNT_W'(n_w);
    k_cnt  = CNT_W'(k_w);
    n_last = n_cnt - 1'b1;
  end

  assign cur     = mask_q[ptr_q];
  assign at_end  = (CNT_W'(ptr_q) == n_last);
  assign is_last = (rcnt_q == n_last);
  assign used    = (OUT_CNT_W + 1)'(out_count_i) + (OUT_CNT_W + 1)'(meta_valid_q);
  assign space   = (used < (OUT_CNT_W + 1)'(OutDepth));

  // The moved element lands one place up; the ones above it follow directly behind.
  always_comb begin
    adv_hi = SUM_W'(ptr_q) + SUM_W'(ones_q) + SUM_W'(1);
    for (int j = 0; j < MAX_ELEMENTS; j++) begin
      lane         = SUM_W'(j);
      mask_init[j] = (lane < SUM_W'(k_cnt));
      if (lane < SUM_W'(ptr_q)) begin
        mask_adv[j] = mask_q[j];
      end else begin
        mask_adv[j] = (lane > SUM_W'(ptr_q)) && (lane <= adv_hi);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    started_d    = started_q;
    done_d       = done_q;
    mask_d       = mask_q;
    ptr_d        = ptr_q;
    prev_d       = prev_q;
    ones_d       = ones_q;
    rcnt_d       = rcnt_q;
    meta_valid_d = 1'b0;
    meta_d       = meta_q;
    cmd_pop_o    = 1'b0;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_waddr_o  = IDX_W'(cmd_i.load_index);
    ram_wdata_o  = VALUE_WIDTH'(cmd_i.load_value);
    ram_raddr_o  = ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_LOAD: begin
              ram_we_o = 1'b1;
            end
            CMD_RESTART: begin
              started_d = 1'b0;
              done_d    = 1'b0;
            end
            CMD_NEXT: begin
              if (done_q) begin
                state_d = ST_EXHAUST;
              end else if (!started_q) begin
                started_d = 1'b1;
                mask_d    = mask_init;
                ptr_d     = '0;
                rcnt_d    = '0;
                state_d   = ST_EMIT_IN;
              end else begin
                ptr_d   = IDX_W'(n_last);
                prev_d  = 1'b1;
                ones_d  = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cur && !prev_q) begin
          mask_d  = mask_adv;
          ptr_d   = '0;
          rcnt_d  = '0;
          state_d = ST_EMIT_IN;
        end else begin
          if (cur) begin
            ones_d = ones_q + 1'b1;
          end
          prev_d = cur;
          if (ptr_q == '0) begin
            done_d  = 1'b1;
            state_d = ST_EXHAUST;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      ST_EMIT_IN: begin
        if (space) begin
          if (cur) begin
            ram_re_o              = 1'b1;
            meta_valid_d          = 1'b1;
            meta_d.exhausted      = 1'b0;
            meta_d.element_index  = 4'(ptr_q);
            meta_d.group_position = 4'(rcnt_q);
            meta_d.in_subset      = 1'b1;
            meta_d.last_item      = is_last;
            rcnt_d                = rcnt_q + 1'b1;
          end
          if (at_end) begin
            ptr_d   = '0;
            state_d = ST_EMIT_OUT;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_EMIT_OUT: begin
        if (space) begin
          if (!cur) begin
            ram_re_o              = 1'b1;
            meta_valid_d          = 1'b1;
            meta_d.exhausted      = 1'b0;
            meta_d.element_index  = 4'(ptr_q);
            meta_d.group_position = 4'(rcnt_q - k_cnt);
            meta_d.in_subset      = 1'b0;
            meta_d.last_item      = is_last;
            rcnt_d                = rcnt_q + 1'b1;
          end
          if (at_end) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_EXHAUST: begin
        if (space) begin
          meta_valid_d = 1'b1;
          meta_d       = '0;
          meta_d.exhausted = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      started_d = 1'b0;
      done_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      started_q    <= 1'b0;
      done_q       <= 1'b0;
      mask_q       <= '0;
      ptr_q        <= '0;
      prev_q       <= 1'b0;
      ones_q       <= '0;
      rcnt_q       <= '0;
      meta_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      started_q    <= started_d;
      done_q       <= done_d;
      mask_q       <= mask_d;
      ptr_q        <= ptr_d;
      prev_q       <= prev_d;
      ones_q       <= ones_d;
      rcnt_q       <= rcnt_d;
      meta_valid_q <= meta_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  always_comb begin
    out_push_o                = meta_valid_q;
    out_word_o.element_value  = meta_q.exhausted ? 32'd0 : 32'(ram_rdata_i);
    out_word_o.element_index  = meta_q.element_index;
    out_word_o.group_position = meta_q.group_position;
    out_word_o.in_subset      = meta_q.in_subset;
    out_word_o.last_item      = meta_q.last_item;
    out_word_o.exhausted      = meta_q.exhausted;
  end

endmodule

/* design/k_subset_lexicographic_enumerator.sv */
// Enumerates the k-element subsets of an n-entry value table in lexicographic
// index order. Words pushed on the input queue either load a table entry, request
// the next subset, or restart the enumeration. A next request yields n result
// words (the k chosen entries, then the unchosen ones, the final one flagged
// last) or a single exhausted word once every subset has been reported. The
// input side takes one word per cycle while its two-entry command queue has
// room. The sequencer takes a new command only once the last one is done; a
// next request finds the successor subset by scanning the membership bits from
// the top, then walks the table twice to emit the chosen and unchosen entries.
// Results drain through a four-word output queue, and stalls on the result side
// hold back the sequencer only. Changing a configuration register rewinds the
// enumeration.
module k_subset_lexicographic_enumerator #(
  parameter int unsigned MAX_ELEMENTS = ksle_pkg::MaxElementsDef,
  parameter int unsigned VALUE_WIDTH  = ksle_pkg::ValueWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ksle_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [ksle_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  ksle_pkg::in_t                      in_word_i,
  output logic                               empty,
  input  logic                               pop,
  output ksle_pkg::out_t                     out_word_o
);

  import ksle_pkg::*;

  localparam int unsigned IDX_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned OUT_CNT_W = $clog2(OutDepth + 1);

  logic [CfgDataWidth-1:0] element_count_q, element_count_d;
  logic [CfgDataWidth-1:0] chosen_count_q, chosen_count_d;
  logic                    cfg_we;

  logic                    cmd_valid, cmd_pop;
  cmd_t                    cmd;
  logic                    out_push;
  out_t                    out_word;
  logic [OUT_CNT_W-1:0]    out_count;
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0]  ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_comb begin
    element_count_d = element_count_q;
    chosen_count_d  = chosen_count_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_ELEMENT_COUNT: begin
          element_count_d = cfg_data_i;
        end
        CFG_CHOSEN_COUNT: begin
          chosen_count_d = cfg_data_i;
        end
        default: begin
          element_count_d = element_count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= ElementCountReset;
      chosen_count_q  <= ChosenCountReset;
    end else begin
      element_count_q <= element_count_d;
      chosen_count_q  <= chosen_count_d;
    end
  end

  ksle_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  ksle_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .element_count_i(element_count_q),
    .chosen_count_i (chosen_count_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_push_o     (out_push),
    .out_word_o     (out_word),
    .out_count_i    (out_count),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  ksle_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_ELEMENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ksle_fifo #(
    .item_t(out_t),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_word),
    .full_o (),
    .pop_i  (pop),
    .data_o (out_word_o),
    .empty_o(empty),
    .count_o(out_count)
  );

endmodule

/* design/ksle_checker.sv */
`include "assert_macros.svh"

module ksle_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           empty,
  input logic           pop,
  input ksle_pkg::out_t out_word_i
);

  `KSLE_ASSERT_IMPLY(a_exhausted_clean, clk_i, rst_ni, !empty && out_word_i.exhausted, out_word_i.element_value == '0 && out_word_i.element_index == '0 && out_word_i.group_position == '0 && !out_word_i.in_subset && !out_word_i.last_item, "exhausted word has nonzero fields")
  `KSLE_ASSERT_IMPLY(a_index_covers_pos, clk_i, rst_ni, !empty, out_word_i.element_index >= out_word_i.group_position, "element index below its group position")
  `KSLE_ASSERT_NEXT(a_head_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_word_i), "result head changed while stalled")

endmodule

bind k_subset_lexicographic_enumerator ksle_checker u_ksle_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_word_i(out_word_o)
);

/* tb/subset_checker.sv */
`timescale 1ns / 1ps

module subset_checker
  import ksle_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     push,
  input  logic                     full,
  input  in_t                      in_word_i,
  input  logic                     empty,
  input  logic                     pop,
  input  out_t                     out_word_i,
  output int                       mismatches_o,
  output int                       waiting_o,
  output int                       results_o,
  output int                       exhausted_o
);

  localparam int unsigned Slots = MaxElementsDef;

  logic [31:0]             slot_value [Slots];
  logic [3:0]              pick [Slots];
  logic                    started_q;
  logic                    done_q;
  logic [CfgDataWidth-1:0] n_reg;
  logic [CfgDataWidth-1:0] k_reg;
  out_t                    expected_words [$];
  out_t                    want;
  int                      mismatches = 0;
  int                      waiting = 0;
  int                      results = 0;
  int                      exhausted_cnt = 0;

  assign mismatches_o = mismatches;
  assign waiting_o    = waiting;
  assign results_o    = results;
  assign exhausted_o  = exhausted_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    $display("%0t ns mismatch: %s got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  task automatic queue_element(input int idx, input int pos, input bit ins, input bit last);
    out_t w;
    w                = '0;
    w.element_value  = slot_value[idx];
    w.element_index  = idx[3:0];
    w.group_position = pos[3:0];
    w.in_subset      = ins;
    w.last_item      = last;
    expected_words.push_back(w);
  endtask

  // Successor in lexicographic order: bump the rightmost index that still has
  // room, then pack everything after it directly behind it.
  task automatic predict_words(input in_t w);
    int         n;
    int         k;
    int         i;
    int         j;
    int         c;
    int         u;
    bit         moved;
    logic [Slots-1:0] member;
    out_t       ow;
    case (w.operation)
      OP_LOAD: slot_value[w.load_index] = w.load_value;
      OP_RESTART: begin
        started_q = 1'b0;
        done_q    = 1'b0;
      end
      OP_NEXT: begin
        n = (n_reg == 0) ? 1 : ((n_reg > Slots) ? Slots : int'(n_reg));
        k = (k_reg > n) ? n : int'(k_reg);
        if (!done_q) begin
          if (!started_q) begin
            for (i = 0; i < k; i++) pick[i] = i[3:0];
            started_q = 1'b1;
          end else begin
            moved = 1'b0;
            i = k;
            while (i > 0 && !moved) begin
              i--;
              if (int'(pick[i]) < n - k + i) begin
                pick[i] = pick[i] + 4'd1;
                for (j = i + 1; j < k; j++) pick[j] = pick[j-1] + 4'd1;
                moved = 1'b1;
              end
            end
            if (!moved) done_q = 1'b1;
          end
        end
        if (done_q) begin
          ow           = '0;
          ow.exhausted = 1'b1;
          expected_words.push_back(ow);
        end else begin
          member = '0;
          c = 0;
          for (i = 0; i < k; i++) begin
            member[pick[i]] = 1'b1;
            queue_element(int'(pick[i]), i, 1'b1, c == n - 1);
            c++;
          end
          u = 0;
          for (i = 0; i < n; i++) begin
            if (!member[i]) begin
              queue_element(i, u, 1'b0, c == n - 1);
              u++;
              c++;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slot_value[i] = '0;
        pick[i]       = '0;
      end
      started_q = 1'b0;
      done_q    = 1'b0;
      n_reg     = ElementCountReset;
      k_reg     = ChosenCountReset;
      expected_words.delete();
      waiting = 0;
    end else begin
      if (pop && !empty) begin
        results++;
        if (out_word_i.exhausted) exhausted_cnt++;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with no expectation", out_word_i.element_value, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_i.element_value !== want.element_value)
            report_mismatch("element_value", out_word_i.element_value, want.element_value);
          if (out_word_i.element_index !== want.element_index)
            report_mismatch("element_index", 32'(out_word_i.element_index),
                            32'(want.element_index));
          if (out_word_i.group_position !== want.group_position)
            report_mismatch("group_position", 32'(out_word_i.group_position),
                            32'(want.group_position));
          if (out_word_i.in_subset !== want.in_subset)
            report_mismatch("in_subset", 32'(out_word_i.in_subset), 32'(want.in_subset));
          if (out_word_i.last_item !== want.last_item)
            report_mismatch("last_item", 32'(out_word_i.last_item), 32'(want.last_item));
          if (out_word_i.exhausted !== want.exhausted)
            report_mismatch("exhausted", 32'(out_word_i.exhausted), 32'(want.exhausted));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ELEMENT_COUNT) begin
          n_reg = cfg_data_i;
        end else begin
          k_reg = cfg_data_i;
        end
        started_q = 1'b0;
        done_q    = 1'b0;
      end
      if (push && !full) predict_words(in_word_i);
      waiting = expected_words.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ksle_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam logic [1:0]  OpUnused   = 2'd3;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;
  logic                     push      = 1'b0;
  logic                     full;
  in_t                      in_word   = '0;
  logic                     empty;
  logic                     pop       = 1'b0;
  out_t                     out_word;
  logic                     hold_req  = 1'b0;

  int mismatches;
  int waiting;
  int results_seen;
  int exhausted_seen;
  int items_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  logic [31:0] seed_values [16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h1234_5678,
    32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'h0000_0000, 32'h0000_0001, 32'hC001_D00D, 32'h0001_0000
  };

  k_subset_lexicographic_enumerator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word)
  );

  subset_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .in_word_i    (in_word),
    .empty        (empty),
    .pop          (pop),
    .out_word_i   (out_word),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .results_o    (results_seen),
    .exhausted_o  (exhausted_seen)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("timeout after %0d cycles without a handshake", StallLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // The result side switches between several stall styles, and once holds
  // off long enough for both internal queues to fill.
  initial begin : receiver
    int         mode;
    int         span;
    int         hold_count;
    bit         held;
    logic [7:0] pattern;
    mode       = 0;
    span       = 0;
    hold_count = 0;
    held       = 1'b0;
    pattern    = 8'hB7;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held       = 1'b1;
        hold_count = 300;
      end
      if (hold_count > 0) begin
        hold_count--;
        pop <= 1'b0;
      end else begin
        if (span == 0) begin
          mode    = $urandom_range(0, 3);
          span    = $urandom_range(8, 48);
          pattern = 8'($urandom);
        end
        span--;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: begin
            pop <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input in_t w);
    @(negedge clk_i);
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    if (w.operation != OpUnused) items_sent++;
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic set_counts(input logic [CfgDataWidth-1:0] n, input logic [CfgDataWidth-1:0] k);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ELEMENT_COUNT;
    cfg_data  <= n;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_index <= CFG_CHOSEN_COUNT;
    cfg_data  <= k;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  function automatic in_t random_word();
    in_t w;
    int  r;
    r            = $urandom_range(0, 99);
    w.load_index = 4'($urandom);
    w.load_value = $urandom;
    if ($urandom_range(0, 7) == 0) w.load_value = $urandom_range(0, 1) ? '1 : '0;
    if (r < 55) begin
      w.operation = OP_NEXT;
    end else if (r < 75) begin
      w.operation = OP_LOAD;
    end else if (r < 90) begin
      w.operation = OP_RESTART;
    end else begin
      w.operation = OpUnused;
    end
    return w;
  endfunction

  task automatic run_random(input int count);
    int  taken;
    in_t w;
    taken = 0;
    while (taken < count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 10));
      end
      w = random_word();
      send_word(w);
      burst_left--;
      if (w.operation != OpUnused) taken++;
    end
  endtask

  task automatic run_phase(input logic [CfgDataWidth-1:0] n,
                           input logic [CfgDataWidth-1:0] k, input int count);
    drain();
    set_counts(n, k);
    run_random(count);
  endtask

  initial begin : stimulus
    in_t w;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole table first so that no unwritten entry is ever reported.
    for (int i = 0; i < 16; i++) begin
      w.operation  = OP_LOAD;
      w.load_index = i[3:0];
      w.load_value = seed_values[i];
      send_word(w);
    end
    w.operation = OP_NEXT;
    send_word(w);
    send_word(w);
    w.operation  = OpUnused;
    w.load_index = 4'hF;
    w.load_value = '1;
    send_word(w);
    w.operation = OP_RESTART;
    send_word(w);
    w.operation = OP_NEXT;
    send_word(w);

    run_phase(5'd4, 5'd2, 24);
    run_phase(5'd0, 5'd3, 14);
    run_phase(5'd16, 5'd16, 16);
    run_phase(5'd16, 5'd0, 20);
    drain();
    set_counts(5'd31, 5'd2);
    hold_req <= 1'b1;
    run_random(40);
    run_phase(5'd5, 5'd31, 20);
    run_phase(5'd7, 5'd3, 40);
    run_phase(5'd3, 5'd0, 20);
    drain();

    $display("Sent %0d input words across %0d register writes; checked %0d result words,",
             items_sent, cfg_writes, results_seen);
    $display("%0d of them exhausted markers, with n from 1 to 16 and k from 0 to n.",
             exhausted_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ksle_pkg.sv
design/ksle_ram.sv
design/ksle_fifo.sv
design/ksle_front.sv
design/ksle_back.sv
design/k_subset_lexicographic_enumerator.sv
design/ksle_checker.sv
tb/subset_checker.sv
tb/tb.sv
